>>> rtl/rotated_box_circle_hit_test_core_assert.svh
// Assertion macros shared by the hit test RTL.
`ifndef ROTATED_BOX_CIRCLE_HIT_TEST_CORE_ASSERT_SVH
`define ROTATED_BOX_CIRCLE_HIT_TEST_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/rbc_pkg.sv
//------------------------------------------------------------------------------
// rbc_pkg
// Shared types, constants and the sine table for the box versus circle test.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package rbc_pkg;
  localparam int CoordW = 16;
  localparam int SizeW = 13;
  localparam int AngW = 10;
  localparam int RadW = 12;
  localparam int TrigW = 16;
  localparam int OffW = 19;
  localparam int ProdW = 35;
  localparam int RotW = 22;
  localparam int NumLanes = 2;
  localparam logic [RadW-1:0] RadiusReset = 12'd160;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROT,
    ST_TEST
  } rbc_state_t;

  typedef struct packed {
    logic mul_en;
    logic rot_en;
    logic test_en;
  } rbc_ctrl_t;

  function automatic logic [14:0] sin_tab(input logic [6:0] d);
    logic [14:0] v;
    case (d)
      7'd0: v = 15'd0; 7'd1: v = 15'd286; 7'd2: v = 15'd572; 7'd3: v = 15'd857;
      7'd4: v = 15'd1143; 7'd5: v = 15'd1428; 7'd6: v = 15'd1713; 7'd7: v = 15'd1997;
      7'd8: v = 15'd2280; 7'd9: v = 15'd2563; 7'd10: v = 15'd2845; 7'd11: v = 15'd3126;
      7'd12: v = 15'd3406; 7'd13: v = 15'd3686; 7'd14: v = 15'd3964; 7'd15: v = 15'd4240;
      7'd16: v = 15'd4516; 7'd17: v = 15'd4790; 7'd18: v = 15'd5063; 7'd19: v = 15'd5334;
      7'd20: v = 15'd5604; 7'd21: v = 15'd5872; 7'd22: v = 15'd6138; 7'd23: v = 15'd6402;
      7'd24: v = 15'd6664; 7'd25: v = 15'd6924; 7'd26: v = 15'd7182; 7'd27: v = 15'd7438;
      7'd28: v = 15'd7692; 7'd29: v = 15'd7943; 7'd30: v = 15'd8192; 7'd31: v = 15'd8438;
      7'd32: v = 15'd8682; 7'd33: v = 15'd8923; 7'd34: v = 15'd9162; 7'd35: v = 15'd9397;
      7'd36: v = 15'd9630; 7'd37: v = 15'd9860; 7'd38: v = 15'd10087; 7'd39: v = 15'd10311;
      7'd40: v = 15'd10531; 7'd41: v = 15'd10749; 7'd42: v = 15'd10963; 7'd43: v = 15'd11174;
      7'd44: v = 15'd11381; 7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
      7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551; 7'd51: v = 15'd12733;
      7'd52: v = 15'd12911; 7'd53: v = 15'd13085; 7'd54: v = 15'd13255; 7'd55: v = 15'd13421;
      7'd56: v = 15'd13583; 7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
      7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466; 7'd63: v = 15'd14598;
      7'd64: v = 15'd14726; 7'd65: v = 15'd14849; 7'd66: v = 15'd14968; 7'd67: v = 15'd15082;
      7'd68: v = 15'd15191; 7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
      7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749; 7'd75: v = 15'd15826;
      7'd76: v = 15'd15897; 7'd77: v = 15'd15964; 7'd78: v = 15'd16026; 7'd79: v = 15'd16083;
      7'd80: v = 15'd16135; 7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
      7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344; 7'd87: v = 15'd16362;
      7'd88: v = 15'd16374; 7'd89: v = 15'd16382; 7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Signed sine of an angle already reduced to 0..359.
  function automatic logic signed [TrigW-1:0] sin_deg(input logic [8:0] a);
    logic [14:0] v;
    logic neg;
    v = '0;
    neg = 1'b0;
    if (a <= 9'd90) begin
      v = sin_tab(a[6:0]);
    end else if (a <= 9'd180) begin
      v = sin_tab(7'(9'd180 - a));
    end else if (a <= 9'd270) begin
      v = sin_tab(7'(a - 9'd180));
      neg = 1'b1;
    end else begin
      v = sin_tab(7'(9'd360 - a));
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction
endpackage

>>> rtl/rbc_lane.sv
//------------------------------------------------------------------------------
// rbc_lane
// One circle centre: rotation into the box frame and the rounded box test.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotated_box_circle_hit_test_core_assert.svh"
module rbc_lane
  import rbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  rbc_ctrl_t                  ctrl,
  input  logic signed [OffW-1:0]     x2,
  input  logic signed [OffW-1:0]     y2,
  input  logic signed [TrigW-1:0]    cos_v,
  input  logic signed [TrigW-1:0]    sin_v,
  input  logic [SizeW-1:0]           w,
  input  logic [SizeW-1:0]           h,
  input  logic [RadW:0]              r,
  output logic                       hit
);
  logic signed [ProdW-1:0] cx_r, sy_r, cy_r, sx_r;
  logic signed [RotW-1:0] px_r, py_r;
  logic hit_r;
  logic signed [ProdW:0] sum_x, sum_y;
  logic signed [RotW+1:0] wi, hi, ri, ax, ay, dx, dy;
  logic signed [2*RotW+4:0] d2, r2;
  logic in_box, corner;

  always_comb begin
    sum_x = (ProdW+1)'(cx_r) + (ProdW+1)'(sy_r) + (ProdW+1)'(15'sd8192);
    sum_y = (ProdW+1)'(cy_r) - (ProdW+1)'(sx_r) + (ProdW+1)'(15'sd8192);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      cx_r <= ProdW'(cos_v * x2);
      sy_r <= ProdW'(sin_v * y2);
      cy_r <= ProdW'(cos_v * y2);
      sx_r <= ProdW'(sin_v * x2);
    end
    if (ctrl.rot_en) begin
      px_r <= RotW'(sum_x >>> 14);
      py_r <= RotW'(sum_y >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.test_en) begin
      hit_r <= in_box && !corner;
    end
  end

  always_comb begin
    wi = (RotW+2)'($signed({1'b0, w}));
    hi = (RotW+2)'($signed({1'b0, h}));
    ri = (RotW+2)'($signed({1'b0, r}));
    ax = (RotW+2)'(px_r);
    ay = (RotW+2)'(py_r);
    in_box = (ax > -wi - ri) && (ax < wi + ri) && (ay > -hi - ri) && (ay < hi + ri);
    dx = (ax < -wi) ? ax + wi : ax - wi;
    dy = (ay < -hi) ? ay + hi : ay - hi;
    d2 = (2*RotW+5)'(dx * dx) + (2*RotW+5)'(dy * dy);
    r2 = (2*RotW+5)'(ri * ri);
    corner = (ax < -wi || ax > wi) && (ay < -hi || ay > hi) && (d2 >= r2);
  end

  assign hit = hit_r;

  `RBC_ASSERT_NEXT(a_lane_zero_r, ctrl.test_en && r == '0 && (w == '0 || h == '0), !hit_r, "hit with zero radius on a flat box")
  `RBC_ASSERT_NEXT(a_lane_hold, !ctrl.test_en, hit_r == $past(hit_r), "hit changed")
  `RBC_ASSERT_IMPL(a_lane_excl, ctrl.mul_en, !ctrl.test_en, "overlapping phases")
endmodule

>>> rtl/rotated_box_circle_hit_test_core.sv
//------------------------------------------------------------------------------
// rotated_box_circle_hit_test_core
// Tests two circle centres against a rotated box with rounded corners.
//------------------------------------------------------------------------------
// Each request passes through a chain of registers: offsets and the sine
// lookup are registered at acceptance, then the multipliers, the rounding,
// the box test and the merge into the frame code each register in turn
// before the result is valid. One request is in flight at a time, and the
// next is taken the cycle after the result is taken. Two lanes handle the
// two centres in parallel.
`timescale 1ns / 1ps
`include "rotated_box_circle_hit_test_core_assert.svh"
module rotated_box_circle_hit_test_core
  import rbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [11:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // box_left, box_top, box_width, box_height, angle_deg, first_x, first_y,
  // second_x, second_y, zero fill
  input  logic [135:0] in_tdata,
  input  logic         in_tuser,   // frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // hit_first, hit_second, frame_code, zero fill
);
  rbc_state_t state_r, state_nxt;
  rbc_ctrl_t ctrl;
  logic [RadW-1:0] radius_r;
  logic [1:0] code_r;
  logic start_r, out_valid_r, merge_r, merge_nxt;
  logic [1:0] hits_r;
  logic signed [OffW-1:0] x2_r [NumLanes];
  logic signed [OffW-1:0] y2_r [NumLanes];
  logic signed [TrigW-1:0] sin_r, cos_r;
  logic [SizeW-1:0] w_r, h_r;
  logic [NumLanes-1:0] hit;
  logic signed [CoordW-1:0] left, top;
  logic signed [AngW-1:0] ang;
  logic signed [AngW+1:0] ang_x;
  logic [8:0] a_mod, a_cos;
  logic accept;

  assign left = in_tdata[15:0];
  assign top = in_tdata[31:16];
  assign ang = in_tdata[67:58];
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !merge_r && !out_valid_r;

  always_comb begin
    ang_x = (AngW+2)'(ang);
    if (ang_x >= 12'sd360) a_mod = 9'(ang_x - 12'sd360);
    else if (ang_x >= 12'sd0) a_mod = 9'(ang_x);
    else if (ang_x >= -12'sd360) a_mod = 9'(ang_x + 12'sd360);
    else a_mod = 9'(ang_x + 12'sd720);
    a_cos = (a_mod >= 9'd270) ? a_mod - 9'd270 : a_mod + 9'd90;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_r <= in_tdata[44:32];
      h_r <= in_tdata[57:45];
      start_r <= in_tuser;
      sin_r <= sin_deg(a_mod);
      cos_r <= sin_deg(a_cos);
      for (int i = 0; i < NumLanes; i++) begin
        x2_r[i] <= OffW'(2 * $signed(in_tdata[68+32*i +: 16])) - OffW'(2 * left)
                   - OffW'($signed({1'b0, in_tdata[44:32]}));
        y2_r[i] <= OffW'(2 * $signed(in_tdata[84+32*i +: 16])) - OffW'(2 * top)
                   - OffW'($signed({1'b0, in_tdata[57:45]}));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ROT;
      ST_ROT:  state_nxt = ST_TEST;
      ST_TEST: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    merge_nxt = 1'b0;
    unique case (state_r)
      ST_MUL:  ctrl.mul_en = 1'b1;
      ST_ROT:  ctrl.rot_en = 1'b1;
      ST_TEST: begin
        ctrl.test_en = 1'b1;
        merge_nxt = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    rbc_lane u_lane (
      .clk, .rst_n, .ctrl,
      .x2(x2_r[g]), .y2(y2_r[g]), .cos_v(cos_r), .sin_v(sin_r),
      .w(w_r), .h(h_r), .r({radius_r, 1'b0}), .hit(hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radius_r <= RadiusReset;
      code_r <= '0;
      merge_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      merge_r <= merge_nxt;
      if (cfg_we) radius_r <= cfg_wdata;
      if (merge_r) begin
        out_valid_r <= 1'b1;
        hits_r <= hit;
        if (hit != 2'b00) code_r <= hit;
        else if (start_r) code_r <= '0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0, code_r, hits_r};

  `RBC_ASSERT_IMPL(a_one_req, out_valid_r, !in_tready, "accepted while result pending")
  `RBC_ASSERT_NEXT(a_merge_out, merge_r, out_valid_r, "merge gave no result")
  `RBC_ASSERT_IMPL(a_code_hits, out_valid_r && hits_r != 2'b00, code_r == hits_r, "code disagrees with hits")
endmodule
